// ----- hw/rtl/pps_pkg.sv -----
// Package: shared constants, types and tables for the pure pursuit steering unit.
`default_nettype none
package pps_pkg;
    localparam int CoordW     = 24;
    localparam int AngleW     = 14;
    localparam int CordicIter = 16;
    localparam int CoordFrac  = 10;
    localparam int IterW      = 5;
    localparam int HalfPiQ12  = 6434;

    localparam logic [15:0] LaTimeReset = 16'd256;
    localparam logic [13:0] WheelReset  = 14'd2765;

    localparam logic [0:0] RegLaTime = 1'b0;
    localparam logic [0:0] RegWheel  = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_SQRT    = 10'b0000000010,
        ST_SEG     = 10'b0000000100,
        ST_TSQ     = 10'b0000001000,
        ST_TSQRT   = 10'b0000010000,
        ST_MULA    = 10'b0000100000,
        ST_NORM    = 10'b0001000000,
        ST_CORDIC  = 10'b0010000000,
        ST_ROUND   = 10'b0100000000,
        ST_OUT     = 10'b1000000000
    } state_t;

    function automatic logic [20:0] atan_q20(input logic [IterW-1:0] i);
        logic [20:0] v;
        unique case (i)
            5'd0:  v = 21'd823550;
            5'd1:  v = 21'd486170;
            5'd2:  v = 21'd256879;
            5'd3:  v = 21'd130396;
            5'd4:  v = 21'd65451;
            5'd5:  v = 21'd32757;
            5'd6:  v = 21'd16383;
            5'd7:  v = 21'd8192;
            5'd8:  v = 21'd4096;
            5'd9:  v = 21'd2048;
            5'd10: v = 21'd1024;
            5'd11: v = 21'd512;
            5'd12: v = 21'd256;
            5'd13: v = 21'd128;
            5'd14: v = 21'd64;
            5'd15: v = 21'd32;
            5'd16: v = 21'd16;
            5'd17: v = 21'd8;
            5'd18: v = 21'd4;
            5'd19: v = 21'd2;
            5'd20: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/pure_pursuit_steering_unit.sv -----
// Top level: pure pursuit steering unit with a shared square root and CORDIC datapath.
// One path point per transaction. A first point that is not the last is accepted and the
// unit is ready again on the next cycle. A later point runs a 25-step bit-pair square root
// on the squared segment length, then adds it to the run and compares it in a segment
// state. A last point then adds a load state, a second 25-step square root for the
// target range, a product state, a one-bit-per-cycle normalization, 16 CORDIC iterations,
// a rounding state and an output state. The result is held until taken. The unit takes
// no transaction while busy or while a result waits.
`default_nettype none
module pure_pursuit_steering_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [23:0]  point_x,
    input  wire logic signed [23:0]  point_y,
    input  wire logic [15:0]         ego_speed,
    input  wire logic                last_point,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [13:0]       steering_angle
);
    pps_pkg::state_t state_reg, state_next;

    logic [15:0] la_time_reg;
    logic [13:0] wheel_reg;
    logic signed [23:0] prev_x_reg, prev_y_reg, tx_reg, ty_reg;
    logic signed [23:0] seg_x_reg, seg_y_reg;
    logic        in_path_reg, found_reg, last_reg;
    logic [31:0] run_reg, la_reg;
    logic [49:0] rem_reg;
    logic [25:0] root_reg;
    logic [4:0]  cnt_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [23:0] cz_reg;
    logic [63:0] a_reg, b_reg;
    logic signed [13:0] ang_reg;
    logic        oval_reg;

    wire accept = in_valid && !in_stall;
    assign in_stall = (state_reg != pps_pkg::ST_IDLE) || oval_reg;
    assign out_valid = oval_reg;
    assign steering_angle = ang_reg;

    // square-root step on rem_reg, bit pair at cnt_reg
    logic [49:0] sq_trial;
    logic [49:0] sq_cur;
    logic [5:0]  sq_sh;
    always_comb
    begin
        sq_sh = {cnt_reg, 1'b0};
        sq_cur = rem_reg;
        sq_trial = ({24'd0, root_reg} << 2 | 50'd1) << sq_sh;
    end

    logic signed [24:0] dx, dy;
    logic [24:0] adx, ady;
    always_comb
    begin
        dx = 25'(point_x) - 25'(prev_x_reg);
        dy = 25'(point_y) - 25'(prev_y_reg);
        adx = dx[24] ? 25'(-dx) : 25'(dx);
        ady = dy[24] ? 25'(-dy) : 25'(dy);
    end

    logic [31:0] la_raw;
    assign la_raw = 32'(({16'd0, ego_speed} * {16'd0, la_time_reg})
                    >> (16 - pps_pkg::CoordFrac));

    logic [23:0] atx, aty;
    assign atx = tx_reg[23] ? 24'(-tx_reg) : 24'(tx_reg);
    assign aty = ty_reg[23] ? 24'(-ty_reg) : 24'(ty_reg);

    logic [32:0] seg_sum;
    assign seg_sum = {1'b0, run_reg} + {7'd0, root_reg};

    logic signed [35:0] xs, ys;
    assign xs = cx_reg >>> cnt_reg;
    assign ys = cy_reg >>> cnt_reg;

    logic [24:0] zr;
    assign zr = 25'(cz_reg < 0 ? 24'sd0 : cz_reg) + 25'd128;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pps_pkg::ST_IDLE;
            la_time_reg <= pps_pkg::LaTimeReset;
            wheel_reg   <= pps_pkg::WheelReset;
            in_path_reg <= 1'b0;
            found_reg   <= 1'b0;
            last_reg    <= 1'b0;
            oval_reg    <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            seg_x_reg   <= '0;
            seg_y_reg   <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            run_reg     <= '0;
            la_reg      <= '0;
            rem_reg     <= '0;
            root_reg    <= '0;
            cnt_reg     <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            cz_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            ang_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pps_pkg::RegLaTime: la_time_reg <= cfg_data;
                    pps_pkg::RegWheel:  wheel_reg   <= cfg_data[13:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                oval_reg <= 1'b0;
            unique case (state_reg)
                pps_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg   <= last_point;
                        prev_x_reg <= point_x;
                        prev_y_reg <= point_y;
                        if (!in_path_reg)
                        begin
                            la_reg <= (la_raw > (32'd2 << pps_pkg::CoordFrac)) ? la_raw
                                      : (32'd2 << pps_pkg::CoordFrac);
                            run_reg <= '0;
                            found_reg <= 1'b0;
                            tx_reg <= point_x;
                            ty_reg <= point_y;
                            in_path_reg <= !last_point;
                        end
                        else
                        begin
                            seg_x_reg <= prev_x_reg;
                            seg_y_reg <= prev_y_reg;
                            rem_reg <= 50'({25'd0, adx} * {25'd0, adx})
                                     + 50'({25'd0, ady} * {25'd0, ady});
                            root_reg <= '0;
                            cnt_reg <= 5'd24;
                            in_path_reg <= !last_point;
                        end
                    end
                end
                pps_pkg::ST_SQRT, pps_pkg::ST_TSQRT:
                begin
                    if (sq_cur >= sq_trial)
                    begin
                        rem_reg  <= sq_cur - sq_trial;
                        root_reg <= {root_reg[24:0], 1'b1};
                    end
                    else
                        root_reg <= {root_reg[24:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                end
                pps_pkg::ST_SEG:
                begin
                    run_reg <= seg_sum[32] ? 32'hFFFF_FFFF : seg_sum[31:0];
                    if (!found_reg && (seg_sum[32] || seg_sum[31:0] >= la_reg))
                    begin
                        found_reg <= 1'b1;
                        tx_reg <= seg_x_reg;
                        ty_reg <= seg_y_reg;
                    end
                end
                pps_pkg::ST_TSQ:
                begin
                    rem_reg <= 50'({26'd0, atx} * {26'd0, atx})
                             + 50'({26'd0, aty} * {26'd0, aty});
                    root_reg <= '0;
                    cnt_reg <= 5'd24;
                end
                pps_pkg::ST_MULA:
                begin
                    a_reg <= {38'd0, root_reg} * {32'd0, la_reg};
                    b_reg <= {49'd0, wheel_reg, 1'b0} * {40'd0, aty};
                end
                pps_pkg::ST_NORM:
                begin
                    if (a_reg >= 64'd1 << 30 || b_reg >= 64'd1 << 30)
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                    end
                    else
                    begin
                        cx_reg <= 36'(a_reg[29:0]);
                        cy_reg <= 36'(b_reg[29:0]);
                        cz_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                pps_pkg::ST_CORDIC:
                begin
                    if (!cy_reg[35])
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + 24'(pps_pkg::atan_q20(cnt_reg));
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - 24'(pps_pkg::atan_q20(cnt_reg));
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                end
                pps_pkg::ST_ROUND:
                begin
                    if (root_reg == '0 || b_reg == '0)
                        ang_reg <= '0;
                    else if (zr[24:8] > 17'(pps_pkg::HalfPiQ12))
                        ang_reg <= ty_reg[23] ? -14'sd6434 : 14'sd6434;
                    else
                        ang_reg <= ty_reg[23] ? 14'(-$signed({1'b0, zr[20:8]}))
                                              : 14'($signed({1'b0, zr[20:8]}));
                end
                pps_pkg::ST_OUT:
                    oval_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
                if (accept)
                    state_next = in_path_reg ? pps_pkg::ST_SQRT
                               : (last_point ? pps_pkg::ST_TSQ : pps_pkg::ST_IDLE);
            pps_pkg::ST_SQRT:
                if (cnt_reg == '0) state_next = pps_pkg::ST_SEG;
            pps_pkg::ST_SEG:
                state_next = last_reg ? pps_pkg::ST_TSQ : pps_pkg::ST_IDLE;
            pps_pkg::ST_TSQ:   state_next = pps_pkg::ST_TSQRT;
            pps_pkg::ST_TSQRT:
                if (cnt_reg == '0) state_next = pps_pkg::ST_MULA;
            pps_pkg::ST_MULA:  state_next = pps_pkg::ST_NORM;
            pps_pkg::ST_NORM:
                if (!(a_reg >= 64'd1 << 30 || b_reg >= 64'd1 << 30))
                    state_next = pps_pkg::ST_CORDIC;
            pps_pkg::ST_CORDIC:
                if (cnt_reg == 5'(pps_pkg::CordicIter - 1)) state_next = pps_pkg::ST_ROUND;
            pps_pkg::ST_ROUND: state_next = pps_pkg::ST_OUT;
            pps_pkg::ST_OUT:   state_next = pps_pkg::ST_IDLE;
            default:           state_next = pps_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/pps_checker.sv -----
// Checker: port-level properties of the pure pursuit steering unit, bound to the top level.
`default_nettype none
module pps_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic signed [13:0] steering_angle
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(steering_angle))
        else $error("result dropped or changed under stall");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> steering_angle <= 14'sd6434 && steering_angle >= -14'sd6434)
        else $error("steering angle out of range");
    a_out_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result repeated after transaction");
    a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
endmodule

bind pure_pursuit_steering_unit pps_checker u_pps_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .steering_angle(steering_angle)
);
`default_nettype wire

// ----- verif/pure_pursuit_steering_unit_tb.sv -----
// Testbench for the pure pursuit steering unit: streams directed and random paths and checks each angle.
`default_nettype none
module pure_pursuit_steering_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic [15:0]        speed;
        logic               last;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = pps_pkg::RegLaTime;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [23:0] point_x = '0;
    logic signed [23:0] point_y = '0;
    logic [15:0] ego_speed = '0;
    logic last_point = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [13:0] steering_angle;

    pure_pursuit_steering_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .point_x(point_x), .point_y(point_y), .ego_speed(ego_speed),
        .last_point(last_point), .out_valid(out_valid), .out_stall(out_stall),
        .steering_angle(steering_angle)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    point_t pending_points[$];
    logic signed [13:0] expected_angles[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len = 0;
    int hold_left = 0;
    bit hold_armed = 1'b1;
    bit hold_req = 0;
    logic accepted_q = 1'b0;

    // predictor state
    logic [15:0] la_time = pps_pkg::LaTimeReset;
    logic [13:0] wheel = pps_pkg::WheelReset;
    logic signed [23:0] last_x, last_y;
    bit path_open;
    logic [31:0] dist_sum, la_dist;
    bit have_target;
    logic signed [23:0] aim_x, aim_y;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] dist_sq(input longint dx, input longint dy);
        longint ax, ay;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    function automatic logic signed [13:0] pursuit_angle(input longint tx, input longint ty,
        input logic [31:0] la, input logic [13:0] wb);
        logic [63:0] r, a, b;
        longint x, y, z, xs, ys;
        bit neg;
        neg = ty < 0;
        r = int_sqrt(dist_sq(tx, ty));
        z = 0;
        if (r == 0) return '0;
        a = r * la;
        b = 64'd2 * wb * (neg ? -ty : ty);
        while (a >= (64'd1 << 30) || b >= (64'd1 << 30))
        begin
            a >>= 1;
            b >>= 1;
        end
        if (b == 0) return '0;
        x = a;
        y = b;
        for (int i = 0; i < pps_pkg::CordicIter; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs;
                z += longint'(pps_pkg::atan_q20(i[pps_pkg::IterW-1:0]));
            end
            else
            begin
                x -= ys; y += xs;
                z -= longint'(pps_pkg::atan_q20(i[pps_pkg::IterW-1:0]));
            end
        end
        if (z < 0) z = 0;
        z = (z + 128) >>> 8;
        if (z > pps_pkg::HalfPiQ12) z = pps_pkg::HalfPiQ12;
        return neg ? -14'(z) : 14'(z);
    endfunction

    task automatic predict_point(input point_t p);
        logic [63:0] seg, total, la;
        if (!path_open)
        begin
            la = (64'(p.speed) * la_time) >> (16 - pps_pkg::CoordFrac);
            la_dist = la > (64'd2 << pps_pkg::CoordFrac) ? la[31:0]
                      : 32'd2 << pps_pkg::CoordFrac;
            dist_sum = 0;
            have_target = 0;
            aim_x = p.px;
            aim_y = p.py;
            path_open = 1;
        end
        else
        begin
            seg = int_sqrt(dist_sq(longint'(p.px) - last_x, longint'(p.py) - last_y));
            total = 64'(dist_sum) + seg;
            dist_sum = total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : total[31:0];
            if (!have_target && dist_sum >= la_dist)
            begin
                have_target = 1;
                aim_x = last_x;
                aim_y = last_y;
            end
        end
        last_x = p.px;
        last_y = p.py;
        if (p.last)
        begin
            path_open = 0;
            expected_angles.push_back(pursuit_angle(aim_x, aim_y, la_dist, wheel));
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || accepted_q)
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    point_t p;
                    p = pending_points.pop_front();
                    point_x <= p.px;
                    point_y <= p.py;
                    ego_speed <= p.speed;
                    last_point <= p.last;
                    in_valid <= 1'b1;
                    predict_point(p);
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= hold_req || ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        accepted_q <= in_valid && !in_stall;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_angles.size() == 0)
                report_mismatch($sformatf("unexpected angle %0d", steering_angle));
            else
            begin
                logic signed [13:0] e;
                e = expected_angles.pop_front();
                if (steering_angle !== e)
                    report_mismatch($sformatf("steering_angle %0d, want %0d",
                        steering_angle, e));
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_armed && hold_len > 0)
        begin
            hold_armed <= 1'b0;
            hold_left <= hold_len;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        hold_req <= (hold_left > 0);
    end

    function automatic logic signed [23:0] rand_coord(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(8192)) - 4096);
            default: return 24'($signed($urandom_range(65536)) - 32768);
        endcase
    endfunction

    task automatic queue_path(input int len, input int mode);
        point_t p;
        for (int k = 0; k < len; k++)
        begin
            p.px = rand_coord(mode);
            p.py = rand_coord(mode);
            p.speed = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8000));
            p.last = (k == len - 1);
            pending_points.push_back(p);
        end
    endtask

    task automatic push_point(input int x, input int y, input int s, input bit l);
        point_t p;
        p.px = 24'(x);
        p.py = 24'(y);
        p.speed = 16'(s);
        p.last = l;
        pending_points.push_back(p);
    endtask

    task automatic drain();
        wait (pending_points.size() == 0);
        @(posedge clk);
        while (in_valid || expected_angles.size() > 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == pps_pkg::RegLaTime) la_time = v;
        else wheel = v[13:0];
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_point(0, 0, 0, 1);
        push_point(8388607, 8388607, 65535, 1);
        push_point(-8388608, -8388608, 65535, 1);
        push_point(5000, 0, 1000, 1);
        push_point(5000, -3000, 500, 0);
        push_point(6000, -2000, 0, 0);
        push_point(8388607, -8388608, 0, 0);
        push_point(-8388608, 8388607, 0, 0);
        push_point(100, 100, 0, 1);
        push_point(3000, 2000, 256, 0);
        push_point(3000, 2000, 256, 0);
        push_point(-3000, 1000, 256, 1);
        drain();
        write_reg(pps_pkg::RegWheel, 16'd0);
        push_point(4000, 3000, 100, 1);
        drain();
        write_reg(pps_pkg::RegLaTime, 16'hFFFF);
        write_reg(pps_pkg::RegWheel, 16'h3FFF);
        push_point(4000, -3000, 65535, 0);
        push_point(8000, -3000, 0, 1);
        push_point(1, -1, 1, 1);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: begin send_idle_pct = 23; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_reg(pps_pkg::RegLaTime, phase == 3 ? 16'd0 : 16'($urandom_range(1024)));
            write_reg(pps_pkg::RegWheel, phase == 4 ? 16'h3FFF : 16'($urandom_range(4000)));
            if (phase == 2) hold_len = 800;
            for (int n = 0; n < 100; )
            begin
                int len;
                len = $urandom_range(4) == 0 ? 1 : $urandom_range(2, 10);
                queue_path(len, $urandom_range(9) == 0 ? 0 : $urandom_range(1, 2));
                n += len;
            end
            drain();
        end

        if (mismatches == 0)
            $display("pure_pursuit_steering_unit_tb OK");
        else
            $display("pure_pursuit_steering_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("pure_pursuit_steering_unit_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
